/* rtl/pmd_pkg.sv */
package pmd_pkg;

  // Field widths.
  localparam int ADC_W  = 10;
  localparam int ANG_W  = 12;
  localparam int ERR_W  = 13;
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = 32;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 8;
  localparam int FRAC_W = 8;

  // Sensor scaling: angle = pot * ANGLE_FULL_SCALE / ADC_FULL_CODE, truncated.
  localparam int ADC_FULL_CODE    = 1023;
  localparam int ANGLE_FULL_SCALE = 3600;

  // The division by ADC_FULL_CODE is a multiply by a rounded-up reciprocal.
  // With the shift set to the numerator width plus ceil(log2(divisor)) the
  // quotient is exact for every numerator of PROD_W bits.
  localparam int PROD_W   = ADC_W + $clog2(ANGLE_FULL_SCALE + 1);
  localparam int RECIP_SH = PROD_W + $clog2(ADC_FULL_CODE);
  localparam int RECIP_W  = PROD_W + 1;
  localparam logic [63:0] RECIP_M_FULL =
    ((64'd1 << RECIP_SH) + 64'(ADC_FULL_CODE) - 64'd1) / 64'(ADC_FULL_CODE);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M_FULL[RECIP_W-1:0];
  localparam int FULL_W = PROD_W + RECIP_W;
  localparam int QUO_W  = FULL_W - RECIP_SH;

  // Product and accumulator widths.
  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PI_W  = GAIN_W + SUM_W;
  localparam int PD_W  = GAIN_W + DIFF_W;
  localparam int ACC_W = PI_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT  = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  output_limit;
    logic [ANG_W-1:0]  angle_limit;
  } cfg_t;

  // One sample after the error stage.
  typedef struct packed {
    logic             valid;
    logic             drive_enable;
    logic             forward;
    logic [ERR_W-1:0] error;
  } err_t;

endpackage

/* rtl/pmd_cfg.sv */
module pmd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pmd_pkg::cfg_t                   cfg_o
);

  pmd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= 16'd256;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.output_limit <= 8'd255;
      cfg_r.angle_limit  <= 12'd3600;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmd_pkg::REG_GAIN_P:       cfg_r.gain_p       <= cfg_data;
        pmd_pkg::REG_GAIN_I:       cfg_r.gain_i       <= cfg_data;
        pmd_pkg::REG_GAIN_D:       cfg_r.gain_d       <= cfg_data;
        pmd_pkg::REG_OUTPUT_LIMIT: cfg_r.output_limit <= cfg_data[pmd_pkg::LIM_W-1:0];
        pmd_pkg::REG_ANGLE_LIMIT:  cfg_r.angle_limit  <= cfg_data[pmd_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pmd_err.sv */
// Input register, angle scaling (two multiply stages) and error stage.
module pmd_err (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pmd_pkg::ADC_W-1:0]  in_pot_reading,
  input  logic                       in_switch_pressed,
  input  logic [pmd_pkg::ANG_W-1:0]  in_target_angle,
  input  pmd_pkg::cfg_t              cfg,
  output pmd_pkg::err_t              err_o,
  input  logic                       dn_ready
);

  logic                        v1_r, v2_r, v3_r;
  logic                        load1, load2, load3;

  logic [pmd_pkg::ADC_W-1:0]   pot_r;
  logic                        pressed1_r, pressed2_r;
  logic [pmd_pkg::ANG_W-1:0]   target1_r, target2_r;
  logic [pmd_pkg::PROD_W-1:0]  prod_nxt, prod_r;

  logic [pmd_pkg::FULL_W-1:0]  full;
  logic [pmd_pkg::QUO_W-1:0]   quo;
  logic [pmd_pkg::ANG_W-1:0]   angle;
  logic [pmd_pkg::ERR_W-1:0]   error_nxt, error_r;
  logic                        enable_nxt, enable_r;
  logic                        fwd_nxt, fwd_r;

  assign load3    = !v3_r || dn_ready;
  assign load2    = !v2_r || load3;
  assign load1    = !v1_r || load2;
  assign in_ready = load1;

  assign prod_nxt = {{(pmd_pkg::PROD_W - pmd_pkg::ADC_W){1'b0}}, pot_r}
                    * pmd_pkg::PROD_W'(pmd_pkg::ANGLE_FULL_SCALE);

  always_comb begin
    full = {{pmd_pkg::RECIP_W{1'b0}}, prod_r} * {{pmd_pkg::PROD_W{1'b0}}, pmd_pkg::RECIP_M};
    quo  = full[pmd_pkg::FULL_W-1:pmd_pkg::RECIP_SH];
    if (32'(quo) > 32'(pmd_pkg::ANGLE_FULL_SCALE)) begin
      angle = pmd_pkg::ANG_W'(pmd_pkg::ANGLE_FULL_SCALE);
    end else begin
      angle = pmd_pkg::ANG_W'(quo);
    end
    error_nxt  = {1'b0, target2_r} - {1'b0, angle};
    fwd_nxt    = angle < target2_r;
    enable_nxt = !(pressed2_r && (target2_r >= cfg.angle_limit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (load1) v1_r <= in_valid;
      if (load2) v2_r <= v1_r;
      if (load3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      pot_r      <= in_pot_reading;
      pressed1_r <= in_switch_pressed;
      target1_r  <= in_target_angle;
    end
    if (load2) begin
      prod_r     <= prod_nxt;
      pressed2_r <= pressed1_r;
      target2_r  <= target1_r;
    end
    if (load3) begin
      error_r  <= error_nxt;
      enable_r <= enable_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

  assign err_o.valid        = v3_r;
  assign err_o.drive_enable = enable_r;
  assign err_o.forward      = fwd_r;
  assign err_o.error        = error_r;

endmodule

/* rtl/pmd_pid.sv */
// Integrator and difference stage, gain products, then sum, clamp and output register.
module pmd_pid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmd_pkg::err_t               err_i,
  output logic                        up_ready,
  input  pmd_pkg::cfg_t               cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_drive_enable,
  output logic                        out_forward,
  output logic [pmd_pkg::LIM_W-1:0]   out_duty,
  output logic [pmd_pkg::ERR_W-1:0]   out_error_out
);

  logic load4, load5, load6;
  logic v4_r, v5_r, v6_r;

  // Controller state.
  logic signed [pmd_pkg::ERR_W-1:0]  prev_error_r;
  logic signed [pmd_pkg::SUM_W-1:0]  error_sum_r;

  logic signed [pmd_pkg::ERR_W-1:0]  e_in;
  logic signed [pmd_pkg::DIFF_W-1:0] diff_nxt, diff4_r;
  logic signed [pmd_pkg::SUM_W:0]    sum_wide;
  logic signed [pmd_pkg::SUM_W-1:0]  sum_nxt, sum4_r;
  logic signed [pmd_pkg::ERR_W-1:0]  e4_r;
  logic [pmd_pkg::ERR_W-1:0]         e5_r;
  logic                              en4_r, fwd4_r, en5_r, fwd5_r;

  logic signed [pmd_pkg::PP_W-1:0]   pp_nxt, pp_r;
  logic signed [pmd_pkg::PI_W-1:0]   pi_nxt, pi_r;
  logic signed [pmd_pkg::PD_W-1:0]   pd_nxt, pd_r;

  logic signed [pmd_pkg::ACC_W-1:0]  acc;
  logic signed [pmd_pkg::ACC_W-1:0]  pid;
  logic signed [pmd_pkg::ACC_W-1:0]  lim_s;
  logic signed [pmd_pkg::ACC_W-1:0]  pid_neg;
  logic [pmd_pkg::LIM_W-1:0]         mag;

  assign load6    = !v6_r || out_ready;
  assign load5    = !v5_r || load6;
  assign load4    = !v4_r || load5;
  assign up_ready = load4;

  assign e_in = $signed(err_i.error);

  always_comb begin
    diff_nxt = pmd_pkg::DIFF_W'(e_in) - pmd_pkg::DIFF_W'(prev_error_r);
    sum_wide = (pmd_pkg::SUM_W + 1)'(error_sum_r) + (pmd_pkg::SUM_W + 1)'(e_in);
    if (sum_wide[pmd_pkg::SUM_W] != sum_wide[pmd_pkg::SUM_W-1]) begin
      // Saturate toward the sign of the true sum.
      sum_nxt = sum_wide[pmd_pkg::SUM_W] ? {1'b1, {(pmd_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(pmd_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[pmd_pkg::SUM_W-1:0];
    end
  end

  assign pp_nxt = $signed(cfg.gain_p) * e4_r;
  assign pi_nxt = $signed(cfg.gain_i) * sum4_r;
  assign pd_nxt = $signed(cfg.gain_d) * diff4_r;

  always_comb begin
    acc     = pmd_pkg::ACC_W'(pp_r) + pmd_pkg::ACC_W'(pi_r) + pmd_pkg::ACC_W'(pd_r);
    pid     = acc >>> pmd_pkg::FRAC_W;
    pid_neg = -pid;
    lim_s   = $signed(pmd_pkg::ACC_W'(cfg.output_limit));
    if (pid > lim_s || pid < -lim_s) begin
      mag = cfg.output_limit;
    end else if (pid < 0) begin
      mag = pid_neg[pmd_pkg::LIM_W-1:0];
    end else begin
      mag = pid[pmd_pkg::LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      prev_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (load4) v4_r <= err_i.valid;
      if (load5) v5_r <= v4_r;
      if (load6) v6_r <= v5_r;
      if (load4 && err_i.valid) begin
        prev_error_r <= e_in;
        error_sum_r  <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      e4_r    <= e_in;
      diff4_r <= diff_nxt;
      sum4_r  <= sum_nxt;
      en4_r   <= err_i.drive_enable;
      fwd4_r  <= err_i.forward;
    end
    if (load5) begin
      pp_r   <= pp_nxt;
      pi_r   <= pi_nxt;
      pd_r   <= pd_nxt;
      e5_r   <= e4_r;
      en5_r  <= en4_r;
      fwd5_r <= fwd4_r;
    end
    if (load6) begin
      out_drive_enable <= en5_r;
      out_forward      <= en5_r && fwd5_r;
      out_duty         <= en5_r ? mag : '0;
      out_error_out    <= e5_r;
    end
  end

  assign out_valid = v6_r;

endmodule

/* rtl/pid_motor_drive_top.sv */
// PID position controller for one motor axis. Each input transfer carries one
// control sample: a raw 10-bit potentiometer reading, the limit-switch level and
// the target angle in tenths of a degree. The reading is scaled to an angle,
// truncated and held at full scale, and the error against the target drives a
// PID law with signed Q8.8 gains whose integral term saturates at 32-bit signed
// limits. The floored PID value is clamped to plus or minus output_limit and
// leaves as a duty magnitude with a direction bit. Drive is disabled, with duty
// and direction forced to zero, while the limit switch is pressed and the target
// is at or above angle_limit; the error is reported in every case and the
// controller state advances with every sample. The datapath is a six-stage
// pipeline (input register, the scaling multiply, the reciprocal multiply
// together with the error, integrator and difference, gain products, then sum,
// clamp and the result register), and one sample is taken every cycle while
// the result side is not stalled. Each stage holds while the one after it is
// full and cannot pass its sample on, so back-pressure on the result side
// ripples up stage by stage and bubbles
// are squeezed out. Write the configuration registers only while no samples
// are in flight.
module pid_motor_drive_top (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pmd_pkg::ADC_W-1:0]       in_pot_reading,
  input  logic                            in_switch_pressed,
  input  logic [pmd_pkg::ANG_W-1:0]       in_target_angle,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_enable,
  output logic                            out_forward,
  output logic [pmd_pkg::LIM_W-1:0]       out_duty,
  output logic [pmd_pkg::ERR_W-1:0]       out_error_out
);

  pmd_pkg::cfg_t cfg;
  pmd_pkg::err_t err;
  logic          pid_ready;

  // Register file for gains and limits.
  pmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Angle scaling, error, direction and drive enable.
  pmd_err u_err (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pot_reading    (in_pot_reading),
    .in_switch_pressed (in_switch_pressed),
    .in_target_angle   (in_target_angle),
    .cfg               (cfg),
    .err_o             (err),
    .dn_ready          (pid_ready)
  );

  // PID state, products, clamp and result register.
  pmd_pid u_pid (
    .clk              (clk),
    .rst_n            (rst_n),
    .err_i            (err),
    .up_ready         (pid_ready),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_enable (out_drive_enable),
    .out_forward      (out_forward),
    .out_duty         (out_duty),
    .out_error_out    (out_error_out)
  );

endmodule

/* verif/pid_motor_drive_top_tb.sv */
module pid_motor_drive_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scaling and saturation limits of the controller, kept apart from the RTL.
  localparam longint ADC_SPAN   = 1023;
  localparam longint ANGLE_SPAN = 3600;
  localparam longint TGT_MAX    = (longint'(1) << pmd_pkg::ANG_W) - 1;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;

  localparam int RESET_CYCLES  = 12;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 8;
  localparam int BURST_ITEMS   = 60;
  localparam int INTEG_ITEMS   = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int FEED_DEPTH    = 32;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 20;

  // One control sample as it crosses the input channel.
  typedef struct packed {
    logic [pmd_pkg::ADC_W-1:0] pot;
    logic                      pressed;
    logic [pmd_pkg::ANG_W-1:0] tgt;
  } ctrl_sample_t;

  // One drive command as it leaves on the result channel.
  typedef struct packed {
    logic                      enable;
    logic                      fwd;
    logic [pmd_pkg::LIM_W-1:0] duty;
    logic [pmd_pkg::ERR_W-1:0] err;
  } drive_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                      in_valid          = 1'b0;
  logic                      in_ready;
  logic [pmd_pkg::ADC_W-1:0] in_pot_reading    = '0;
  logic                      in_switch_pressed = 1'b0;
  logic [pmd_pkg::ANG_W-1:0] in_target_angle   = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_drive_enable;
  logic                      out_forward;
  logic [pmd_pkg::LIM_W-1:0] out_duty;
  logic [pmd_pkg::ERR_W-1:0] out_error_out;

  pid_motor_drive_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pot_reading    (in_pot_reading),
    .in_switch_pressed (in_switch_pressed),
    .in_target_angle   (in_target_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_enable  (out_drive_enable),
    .out_forward       (out_forward),
    .out_duty          (out_duty),
    .out_error_out     (out_error_out)
  );

  always #2 clk = ~clk;

  // Samples waiting to be offered, and drive commands predicted for samples
  // that the block has already taken.
  ctrl_sample_t sample_q[$];
  drive_cmd_t   drive_cmd_q[$];

  // Idling knobs and the long receiver hold-off request. The stimulus process
  // changes them with nonblocking writes so the clocked processes never race it.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned mismatches = 0;
  int unsigned idle_run   = 0;

  // Shadow copy of the controller: register file and PID state, starting from
  // their reset values.
  longint kp         = 256;
  longint ki         = 0;
  longint kd         = 0;
  longint duty_limit = 255;
  longint stop_angle = 3600;
  longint prev_err   = 0;
  longint integ      = 0;

  // Advances the shadow controller by one sample and returns the drive command
  // the block must produce for it. The integrator and the previous error move
  // on every sample, whether or not drive ends up enabled.
  function automatic drive_cmd_t control_law(input logic [pmd_pkg::ADC_W-1:0] pot,
                                             input logic pressed,
                                             input logic [pmd_pkg::ANG_W-1:0] tgt);
    longint     ang;
    longint     e;
    longint     diff;
    longint     acc;
    longint     pid;
    drive_cmd_t cmd;
    // The measured angle is truncated, and held at full scale in case the
    // reading ever scales past it.
    ang = (longint'(pot) * ANGLE_SPAN) / ADC_SPAN;
    if (ang > ANGLE_SPAN) ang = ANGLE_SPAN;
    e = longint'(tgt) - ang;
    diff = e - prev_err;
    integ = integ + e;
    if (integ > SUM_MAX) integ = SUM_MAX;
    if (integ < SUM_MIN) integ = SUM_MIN;
    acc = kp * e + ki * integ + kd * diff;
    // Arithmetic shift of a signed value floors toward minus infinity.
    pid = acc >>> pmd_pkg::FRAC_W;
    if (pid > duty_limit) pid = duty_limit;
    if (pid < -duty_limit) pid = -duty_limit;
    prev_err = e;
    cmd.enable = !(pressed && longint'(tgt) >= stop_angle);
    cmd.fwd    = cmd.enable && (ang < longint'(tgt));
    cmd.duty   = cmd.enable ? pmd_pkg::LIM_W'(pid < 0 ? -pid : pid) : '0;
    cmd.err    = pmd_pkg::ERR_W'(e);
    return cmd;
  endfunction

  // Random samples. Half of them sit close to the measured angle so the PID
  // output often stays inside the clamp; the rest span the whole target field,
  // hit its extremes, or land right on the angle limit boundary.
  function automatic ctrl_sample_t random_sample();
    ctrl_sample_t s;
    longint       ang;
    longint       t;
    s.pot     = pmd_pkg::ADC_W'($urandom_range(0, (1 << pmd_pkg::ADC_W) - 1));
    s.pressed = 1'($urandom_range(0, 1));
    ang = (longint'(s.pot) * ANGLE_SPAN) / ADC_SPAN;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: t = ang + longint'($urandom_range(0, 64)) - 32;
      5, 6, 7: t = longint'($urandom_range(0, (1 << pmd_pkg::ANG_W) - 1));
      8: begin
        case ($urandom_range(0, 2))
          0: t = 0;
          1: t = ANGLE_SPAN;
          default: t = TGT_MAX;
        endcase
      end
      default: t = stop_angle + longint'($urandom_range(0, 2)) - 1;
    endcase
    if (t < 0) t = 0;
    if (t > TGT_MAX) t = TGT_MAX;
    s.tgt = pmd_pkg::ANG_W'(t);
    return s;
  endfunction

  // Driver: a new sample goes out whenever the channel is empty or the current
  // one transfers at this edge, unless the sender chooses to idle this cycle.
  always @(posedge clk) begin : drive_samples
    ctrl_sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = sample_q.pop_front();
        in_valid          <= 1'b1;
        in_pot_reading    <= nxt.pot;
        in_switch_pressed <= nxt.pressed;
        in_target_angle   <= nxt.tgt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here once the
  // stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Monitor: tracks register writes, predicts a drive command for every sample
  // transfer and checks every result transfer against the oldest prediction.
  always @(posedge clk) begin : check_drive
    drive_cmd_t got;
    drive_cmd_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pmd_pkg::REG_GAIN_P:       kp = longint'($signed(cfg_data));
          pmd_pkg::REG_GAIN_I:       ki = longint'($signed(cfg_data));
          pmd_pkg::REG_GAIN_D:       kd = longint'($signed(cfg_data));
          pmd_pkg::REG_OUTPUT_LIMIT: duty_limit = longint'(cfg_data[pmd_pkg::LIM_W-1:0]);
          pmd_pkg::REG_ANGLE_LIMIT:  stop_angle = longint'(cfg_data[pmd_pkg::ANG_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_cmd_q.push_back(control_law(in_pot_reading, in_switch_pressed,
                                          in_target_angle));
      if (out_valid && out_ready) begin
        got = {out_drive_enable, out_forward, out_duty, out_error_out};
        if (drive_cmd_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected drive command en=%0b fwd=%0b duty=%0d err=%0d",
                     $realtime, got.enable, got.fwd, got.duty, $signed(got.err));
          mismatches++;
        end else begin
          want = drive_cmd_q.pop_front();
          if (got.enable !== want.enable || got.fwd !== want.fwd ||
              got.duty !== want.duty || got.err !== want.err) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: drive mismatch, expected en=%0b fwd=%0b duty=%0d err=%0d, %s",
                       $realtime, want.enable, want.fwd, want.duty, $signed(want.err),
                       $sformatf("got en=%0b fwd=%0b duty=%0d err=%0d",
                                 got.enable, got.fwd, got.duty, $signed(got.err)));
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: a run of cycles with no transfer on any channel means the block
  // has hung. The longest legal quiet stretch is the receiver hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_run <= 0;
      else
        idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_sample(input int pot, input int pressed, input int tgt);
    ctrl_sample_t s;
    s.pot     = pmd_pkg::ADC_W'(pot);
    s.pressed = 1'(pressed);
    s.tgt     = pmd_pkg::ANG_W'(tgt);
    sample_q.push_back(s);
  endtask

  // Sender pause: returns once every queued sample has transferred and every
  // predicted drive command has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_valid || drive_cmd_q.size() != 0);
  endtask

  // One register write transfer, then a further wait with valid low, so back-to-back
  // writes never raise and lower the valid in the same time step.
  task automatic write_reg(input logic [pmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the full register set. The unused upper bits of the narrow
  // registers carry noise, and one write goes to an unmapped index.
  task automatic program_gains(input int gp, input int gi, input int gd,
                               input int lim, input int alim);
    write_reg(pmd_pkg::REG_GAIN_P, pmd_pkg::CFG_DATA_W'(gp));
    write_reg(pmd_pkg::REG_GAIN_I, pmd_pkg::CFG_DATA_W'(gi));
    write_reg(pmd_pkg::REG_GAIN_D, pmd_pkg::CFG_DATA_W'(gd));
    write_reg(pmd_pkg::REG_OUTPUT_LIMIT, {8'($urandom), 8'(lim)});
    write_reg(pmd_pkg::REG_ANGLE_LIMIT, {4'($urandom), 12'(alim)});
    write_reg(pmd_pkg::CFG_IDX_W'($urandom_range(int'(pmd_pkg::REG_ANGLE_LIMIT) + 1,
                                                 (1 << pmd_pkg::CFG_IDX_W) - 1)),
              pmd_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   <= src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // Streams the same sample many times without letting the stimulus queue
  // grow beyond a small window.
  task automatic feed_repeat(input longint n, input int pot, input int tgt);
    for (longint k = 0; k < n; k++) begin
      while (sample_q.size() >= FEED_DEPTH) @(posedge clk);
      push_sample(pot, 0, tgt);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset register values: zero error at both
    // ends of the sensor range, the largest errors of either sign with the
    // target above full scale among them, truncation of the scaled reading,
    // equal angle and target (no forward), and the limit switch on both sides
    // of the angle limit.
    push_sample(0, 0, 0);
    push_sample(int'(ADC_SPAN), 0, int'(ANGLE_SPAN));
    push_sample(0, 0, int'(TGT_MAX));
    push_sample(int'(ADC_SPAN), 0, 0);
    push_sample(1, 0, 3);
    push_sample(2, 0, 7);
    push_sample(512, 0, 1801);
    push_sample(512, 0, 1802);
    push_sample(0, 1, int'(ANGLE_SPAN));
    push_sample(0, 1, int'(ANGLE_SPAN) - 1);
    push_sample(0, 1, int'(TGT_MAX));
    push_sample(int'(ADC_SPAN), 1, 0);
    push_sample(700, 1, 2000);
    push_sample(341, 0, 1200);
    push_sample(int'(ADC_SPAN) - 1, 0, int'(ANGLE_SPAN));
    wait_drained();

    // Writes to unmapped indexes must leave the register file alone.
    for (int k = int'(pmd_pkg::REG_ANGLE_LIMIT) + 1; k < (1 << pmd_pkg::CFG_IDX_W); k++)
      write_reg(pmd_pkg::CFG_IDX_W'(k), pmd_pkg::CFG_DATA_W'($urandom));
    push_sample(0, 0, 1000);
    push_sample(int'(ADC_SPAN), 1, int'(TGT_MAX));
    wait_drained();

    // A zero clamp and a zero angle limit: duty is always zero, and a pressed
    // switch disables drive for every target.
    write_reg(pmd_pkg::REG_OUTPUT_LIMIT, '0);
    write_reg(pmd_pkg::REG_ANGLE_LIMIT, '0);
    push_sample(0, 1, 0);
    push_sample(0, 0, int'(TGT_MAX));
    push_sample(int'(ADC_SPAN), 1, 5);
    wait_drained();

    // Random phases. The first two use the extreme register settings; the
    // rest use moderate gains so the PID output often lands inside the clamp.
    // The idling pattern rotates through none, sender only, receiver only and
    // both.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_gains(32767, 32767, 32767, 255, int'(TGT_MAX));
        1: program_gains(-32768, -32768, -32768, 0, 0);
        default: program_gains(int'($urandom_range(0, 1024)) - 512,
                               int'($urandom_range(0, 16)) - 8,
                               int'($urandom_range(0, 1024)) - 512,
                               int'($urandom_range(0, 255)),
                               int'($urandom_range(0, (1 << pmd_pkg::ANG_W) - 1)));
      endcase
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(73, 0);
        2: set_idling(0, 73);
        default: set_idling(16, 16);
      endcase
      repeat (PHASE_ITEMS) sample_q.push_back(random_sample());
      wait_drained();

      // Back-pressure burst: the receiver holds off for a long stretch while
      // the sender keeps offering, so the pipeline fills and stalls its input.
      if (p == 3) begin
        set_idling(0, 0);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (BURST_ITEMS) sample_q.push_back(random_sample());
        wait_drained();
      end
    end

    // Integral path alone. With only a unit integral gain the duty shows the
    // running sum divided by 256: the sum is pushed up with the largest error
    // until the duty clamps, then walked back down with the most negative one.
    set_idling(0, 0);
    program_gains(0, 1, 0, 255, int'(TGT_MAX));
    feed_repeat(INTEG_ITEMS, 0, int'(TGT_MAX));
    feed_repeat(INTEG_ITEMS, int'(ADC_SPAN), 0);
    wait_drained();

    // Wait out a settle period so that any stray result is caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && drive_cmd_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
